// ===== rtl/core/pfa_pkg.sv =====
// shared types and constants for the page frame allocator
// no dependencies; imported by pfa_ctrl, pfa_datapath and page_frame_allocator_top
package pfa_pkg;

  // fixed field widths
  localparam int ADDR_W      = 52;
  localparam int CNT_FIELD_W = 13;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_PAGES = 2'd2;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_INIT  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic accept;       // item taken this cycle
    logic stack_step;   // stack entry ready, fetch its bitmap word
    logic bitmap_step;  // bitmap word ready, finish the item
    logic sweep;        // one step of the clear / fill pass
    logic fill;         // sweep also fills the stack
    logic out_load;     // move the result into the output register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_init;     // offered item is an init
    logic req_alloc;    // offered item is an allocate
    logic early_done;   // offered item resolves without memory access
    logic sweep_last;   // current sweep step is the final one
    logic slot_free;    // output register can take a result
  } ctl_stat_t;

endpackage

// ===== rtl/core/pfa_ctrl.sv =====
// sequencing state machine for the page frame allocator
// depends on pfa_pkg (command and status structs)
module pfa_ctrl
  import pfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_STACK  = 5'b00010,
    S_BITMAP = 5'b00100,
    S_SWEEP  = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   from_init_r, from_init_nxt;

  // state registers; reset starts the bitmap clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      from_init_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      from_init_r <= from_init_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    from_init_nxt = from_init_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.req_init) begin
            state_nxt     = S_SWEEP;
            from_init_nxt = 1'b1;
          end else if (stat.early_done) begin
            state_nxt = S_RESP;
          end else if (stat.req_alloc) begin
            state_nxt = S_STACK;
          end else begin
            state_nxt = S_BITMAP;
          end
        end
      end
      S_STACK: begin
        cmd.stack_step = 1'b1;
        state_nxt      = S_BITMAP;
      end
      S_BITMAP: begin
        cmd.bitmap_step = 1'b1;
        state_nxt       = S_RESP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        cmd.fill  = from_init_r;
        if (stat.sweep_last) begin
          from_init_nxt = 1'b0;
          state_nxt     = from_init_r ? S_RESP : S_IDLE;
        end
      end
      S_RESP: begin
        if (stat.slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // items are taken only between operations
  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== rtl/core/pfa_datapath.sv =====
// registers, free stack memory, used bitmap memory and output register
// depends on pfa_pkg; driven by commands from pfa_ctrl
module pfa_datapath
  import pfa_pkg::*;
#(
  parameter int MAX_PAGES = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [ADDR_W-1:0]    in_page_address,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  ctl_cmd_t             cmd,
  output ctl_stat_t            stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [ADDR_W-1:0]    out_granted_page,
  output logic                 out_page_free
);

  localparam int IDX_W    = $clog2(MAX_PAGES);
  localparam int CNT_W    = $clog2(MAX_PAGES + 1);
  // bit select width: only the largest power of two that fits a word is used
  localparam int SEL_W    = $clog2(WORD_BITS + 1) - 1;
  localparam int USE_BITS = 1 << SEL_W;
  localparam int WORD_CNT = (MAX_PAGES + USE_BITS - 1) / USE_BITS;
  localparam int WA_W     = (WORD_CNT > 1) ? $clog2(WORD_CNT) : 1;
  localparam int EC_W     = (CNT_W > CNT_FIELD_W) ? CNT_W : CNT_FIELD_W;
  localparam int SUM_W    = EC_W + 1;

  function automatic logic [WA_W-1:0] word_of(input logic [IDX_W-1:0] i);
    word_of = WA_W'(i >> SEL_W);
  endfunction

  // configuration and control registers
  logic [ADDR_W-1:0]      base_r;
  logic [CNT_FIELD_W-1:0] count_r;
  logic [CNT_FIELD_W-1:0] rsv_r;
  logic [CNT_W-1:0]       fc_r, fc_nxt;
  logic [CNT_W-1:0]       sweep_r, sweep_nxt;
  logic                   out_valid_r;

  // payload registers
  kind_t                  kind_r;
  logic [IDX_W-1:0]       idx_r;
  logic [IDX_W-1:0]       stack_rd_r;
  logic [WORD_BITS-1:0]   bm_rd_r;
  status_t                res_status_r;
  logic [ADDR_W-1:0]      res_granted_r;
  logic                   res_pfree_r;
  status_t                out_status_r;
  logic [ADDR_W-1:0]      out_granted_r;
  logic                   out_pfree_r;

  // memories
  logic [IDX_W-1:0]     stack_mem [MAX_PAGES];
  logic [WORD_BITS-1:0] bitmap_mem [WORD_CNT];

  logic                 stk_we, stk_re;
  logic [IDX_W-1:0]     stk_wa, stk_wd, stk_ra;
  logic                 bm_we, bm_re;
  logic [WA_W-1:0]      bm_wa, bm_ra;
  logic [WORD_BITS-1:0] bm_wd;

  // decode of the offered item
  kind_t              kind_c;
  logic [EC_W-1:0]    eff_c;
  logic [ADDR_W:0]    diff_c;
  logic               in_rng_c;
  logic [IDX_W-1:0]   idx_c;
  logic               fc_zero_c;
  logic [CNT_W-1:0]   fc_dec_c;
  logic               is_fq_c;

  assign kind_c    = kind_t'(in_kind);
  assign eff_c     = (EC_W'(count_r) > EC_W'(MAX_PAGES)) ? EC_W'(MAX_PAGES) : EC_W'(count_r);
  assign diff_c    = {1'b0, in_page_address} - {1'b0, base_r};
  assign in_rng_c  = !diff_c[ADDR_W] && (diff_c[ADDR_W-1:0] < ADDR_W'(eff_c));
  assign idx_c     = diff_c[IDX_W-1:0];
  assign fc_zero_c = (fc_r == '0);
  assign fc_dec_c  = fc_r - CNT_W'(1);
  assign is_fq_c   = (kind_c == KIND_FREE) || (kind_c == KIND_QUERY);

  // sweep bookkeeping
  logic [SUM_W-1:0] fill_pos_c;
  logic             clear_en_c, fill_en_c;

  assign fill_pos_c = SUM_W'(rsv_r) + SUM_W'(sweep_r);
  assign clear_en_c = (sweep_r < CNT_W'(WORD_CNT));
  assign fill_en_c  = cmd.fill && (fill_pos_c < SUM_W'(eff_c));

  // bitmap word of the item in flight
  logic [WORD_BITS-1:0] mask_c;
  logic                 hit_c;
  logic                 push_c;

  assign mask_c = WORD_BITS'(1) << idx_r[SEL_W-1:0];
  assign hit_c  = bm_rd_r[idx_r[SEL_W-1:0]];
  assign push_c = cmd.bitmap_step && (kind_r == KIND_FREE) && hit_c;

  // status to the controller
  always_comb begin
    stat.req_init   = (kind_c == KIND_INIT);
    stat.req_alloc  = (kind_c == KIND_ALLOC);
    stat.early_done = ((kind_c == KIND_ALLOC) && fc_zero_c) || (is_fq_c && !in_rng_c);
    stat.sweep_last = ((SUM_W'(sweep_r) + SUM_W'(1)) >= SUM_W'(WORD_CNT)) &&
                      (!cmd.fill || ((fill_pos_c + SUM_W'(1)) >= SUM_W'(eff_c)));
    stat.slot_free  = !out_valid_r || !out_stall;
  end

  // memory port control
  always_comb begin
    stk_re = cmd.accept && (kind_c == KIND_ALLOC) && !fc_zero_c;
    stk_ra = fc_dec_c[IDX_W-1:0];

    bm_re = (cmd.accept && is_fq_c) || cmd.stack_step;
    bm_ra = cmd.stack_step ? word_of(stack_rd_r) : word_of(idx_c);

    stk_we = 1'b0;
    stk_wa = fc_r[IDX_W-1:0];
    stk_wd = idx_r;
    if (cmd.sweep && fill_en_c) begin
      stk_we = 1'b1;
      stk_wa = sweep_r[IDX_W-1:0];
      stk_wd = fill_pos_c[IDX_W-1:0];
    end else if (push_c && (fc_r < CNT_W'(MAX_PAGES))) begin
      stk_we = 1'b1;
    end

    bm_we = 1'b0;
    bm_wa = word_of(idx_r);
    bm_wd = bm_rd_r & ~mask_c;
    if (cmd.sweep) begin
      bm_we = clear_en_c;
      bm_wa = sweep_r[WA_W-1:0];
      bm_wd = '0;
    end else if (cmd.bitmap_step && (kind_r == KIND_ALLOC)) begin
      bm_we = 1'b1;
      bm_wd = bm_rd_r | mask_c;
    end else if (push_c) begin
      bm_we = 1'b1;
    end
  end

  // free count and sweep counter
  always_comb begin
    fc_nxt    = fc_r;
    sweep_nxt = sweep_r;
    if (cmd.accept && (kind_c == KIND_INIT)) begin
      fc_nxt    = '0;
      sweep_nxt = '0;
    end else if (cmd.accept && (kind_c == KIND_ALLOC) && !fc_zero_c) begin
      fc_nxt = fc_dec_c;
    end else if (cmd.sweep) begin
      sweep_nxt = sweep_r + CNT_W'(1);
      if (fill_en_c) begin
        fc_nxt = fc_r + CNT_W'(1);
      end
    end else if (push_c && (fc_r < CNT_W'(MAX_PAGES))) begin
      fc_nxt = fc_r + CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      count_r     <= CNT_FIELD_W'(4096);
      rsv_r       <= CNT_FIELD_W'(1);
      fc_r        <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BASE_PAGE:      base_r  <= cfg_data;
          CFG_PAGE_COUNT:     count_r <= cfg_data[CNT_FIELD_W-1:0];
          CFG_RESERVED_PAGES: rsv_r   <= cfg_data[CNT_FIELD_W-1:0];
          default: ;
        endcase
      end
      fc_r    <= fc_nxt;
      sweep_r <= sweep_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r        <= kind_c;
      idx_r         <= idx_c;
      res_granted_r <= '0;
      res_pfree_r   <= 1'b0;
      if ((kind_c == KIND_ALLOC) && fc_zero_c) begin
        res_status_r <= ST_NO_FREE;
      end else if (is_fq_c && !in_rng_c) begin
        res_status_r <= ST_RANGE;
      end else begin
        res_status_r <= ST_OK;
      end
    end
    if (cmd.stack_step) begin
      idx_r <= stack_rd_r;
    end
    if (cmd.bitmap_step) begin
      case (kind_r)
        KIND_ALLOC: res_granted_r <= base_r + ADDR_W'(idx_r);
        KIND_FREE:  if (!hit_c) res_status_r <= ST_ALREADY_FREE;
        KIND_QUERY: res_pfree_r <= !hit_c;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_status_r  <= res_status_r;
      out_granted_r <= res_granted_r;
      out_pfree_r   <= res_pfree_r;
    end
  end

  // free stack memory, registered read
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stack_rd_r <= stack_mem[stk_ra];
    end
  end

  // used bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bitmap_mem[bm_wa] <= bm_wd;
    end
    if (bm_re) begin
      bm_rd_r <= bitmap_mem[bm_ra];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_page = out_granted_r;
  assign out_page_free    = out_pfree_r;

endmodule

// ===== rtl/core/page_frame_allocator_top.sv =====
// top level of the page frame allocator: free stack plus used bitmap
// depends on pfa_pkg, pfa_ctrl and pfa_datapath
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | in_kind, in_page_address
//   out     | output    | out_valid/out_stall | out_status, out_granted_page, out_page_free
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one item at a time; allocate goes through a stack read, then a bitmap read-modify-write,
// then the output load; free and query skip the stack read, and an empty allocate or an
// out-of-range address goes straight to the output load. init clears the bitmap and fills
// the stack with free pages, one stack slot and one bitmap word per cycle, then loads its
// result. after reset a clearing pass holds in_stall high; cfg writes are always taken.
// a result waiting under out_stall does not block the next item until its own result.
module page_frame_allocator_top
  import pfa_pkg::*;
#(
  parameter int MAX_PAGES = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [ADDR_W-1:0]    in_page_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [ADDR_W-1:0]    out_granted_page,
  output logic                 out_page_free,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // registers take writes in any cycle
  assign cfg_ready = 1'b1;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfa_datapath #(
    .MAX_PAGES (MAX_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_kind          (in_kind),
    .in_page_address  (in_page_address),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_granted_page (out_granted_page),
    .out_page_free    (out_page_free)
  );

endmodule
